// ===== rtl/rpn_pkg.sv =====
// Shared constants, codes and helpers for the RPN stack calculator.
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;

  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W = 5;
  localparam int DATA_W  = 32;
  localparam int DIV_W   = DATA_W + FRAC_BITS;
  localparam int STEP_W  = $clog2(DIV_W + 1);

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIV0  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^31.
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    r = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
    return r;
  endfunction

endpackage

// ===== rtl/rpn_mul.sv =====
// Registered signed fixed-point multiplier with rescale and saturation.
module rpn_mul (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rpn_pkg::DATA_W-1:0] a,
  input  logic signed [rpn_pkg::DATA_W-1:0] b,
  output logic signed [rpn_pkg::DATA_W-1:0] result
);

  localparam int PW = 2 * rpn_pkg::DATA_W;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

  // Arithmetic shift rounds toward minus infinity.
  assign shifted = prod >>> rpn_pkg::FRAC_BITS;
  assign fits    = (&shifted[PW-1:rpn_pkg::DATA_W-1]) | ~(|shifted[PW-1:rpn_pkg::DATA_W-1]);

  always_comb begin
    if (fits) begin
      result = shifted[rpn_pkg::DATA_W-1:0];
    end else if (shifted[PW-1]) begin
      result = {1'b1, {(rpn_pkg::DATA_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(rpn_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/rpn_div.sv =====
// Restoring divider, one quotient bit per cycle, with sign and saturation.
module rpn_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [rpn_pkg::DATA_W-1:0] left,
  input  logic signed [rpn_pkg::DATA_W-1:0] right,
  output logic                             done,
  output logic signed [rpn_pkg::DATA_W-1:0] quotient
);

  localparam int DW = rpn_pkg::DATA_W;
  localparam int QW = rpn_pkg::DIV_W;

  logic                          busy;
  logic [rpn_pkg::STEP_W-1:0]    step;
  logic [DW-1:0]                 rem;
  logic [QW-1:0]                 quo;
  logic [DW-1:0]                 dvs;
  logic                          neg;
  logic [DW:0]                   rem_sh;
  logic [DW:0]                   diff;
  logic                          ge;
  logic                          ovf;

  assign rem_sh = {rem, quo[QW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == rpn_pkg::STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == rpn_pkg::STEP_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= QW'(rpn_pkg::mag32(left)) << rpn_pkg::FRAC_BITS;
      rem  <= '0;
      dvs  <= rpn_pkg::mag32(right);
      neg  <= left[DW-1] ^ right[DW-1];
      step <= rpn_pkg::STEP_W'(QW);
    end else if (busy) begin
      rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo  <= {quo[QW-2:0], ge};
      step <= step - rpn_pkg::STEP_W'(1);
    end
  end

  // Any quotient bit at or above 2^31 saturates either sign.
  assign ovf = |quo[QW-1:DW-1];

  always_comb begin
    if (ovf) begin
      quotient = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (neg) begin
      quotient = ~quo[DW-1:0] + DW'(1);
    end else begin
      quotient = quo[DW-1:0];
    end
  end

endmodule

// ===== rtl/rpn_stack_calculator.sv =====
// Top level of the RPN stack calculator: stack memory, sequencer and result register.
//
//   channel | signals                      | direction | meaning
//   --------+------------------------------+-----------+------------------------------
//   in      | in_valid, in_stall           | sink      | item: command, value
//           | command[2:0], value[31:0]    |           |
//   out     | out_valid, out_stall         | source    | item: top_value, status, depth
//           | top_value, status, depth     |           |
//
// Path to the output register: push, unknown codes, underflow and full go to S_DONE;
// before it, divide by zero passes S_READ; add/sub S_READ, S_WB; multiply adds S_MUL;
// divide adds S_DIV, one bit per cycle over the 48-bit shifted dividend.
// The stack lives in a 16 x 32 synchronous RAM; the top entry is mirrored in a
// register, so each operator needs a single RAM read of the entry below it.
// Reset clears the depth counter and control state; the RAM is not cleared.
// in_stall is high while an item is in work or its result cannot be handed over.
module rpn_stack_calculator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          command,
  input  logic signed [rpn_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rpn_pkg::DATA_W-1:0]   top_value,
  output logic [1:0]                          status,
  output logic [rpn_pkg::DEPTH_W-1:0]         depth
);

  localparam int DW = rpn_pkg::DATA_W;
  localparam int AW = rpn_pkg::ADDR_W;
  localparam int CW = rpn_pkg::CNT_W;

  rpn_pkg::state_t state, state_next;

  // Stack memory
  logic [DW-1:0] mem [rpn_pkg::STACK_DEPTH];
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;

  // Working registers
  logic [CW-1:0]          cnt;
  logic signed [DW-1:0]   tos;
  logic signed [DW-1:0]   res;
  logic [2:0]             cmd_q;
  rpn_pkg::status_t       res_status;

  // Control
  logic accept;
  logic do_push;
  logic under;
  logic full;
  logic mul_en;
  logic div_start;
  logic div_done;
  logic out_load;
  logic out_free;
  logic signed [DW-1:0] mul_res;
  logic signed [DW-1:0] div_res;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (cnt >= CW'(rpn_pkg::STACK_DEPTH));
  assign under    = (cnt < CW'(2));
  assign do_push  = accept && (command == rpn_pkg::CMD_PUSH) && !full;

  // Read the entry below the top; it is registered into rd_data for the next cycle.
  assign rd_addr = AW'(cnt - CW'(2));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    if (state == rpn_pkg::S_WB) begin
      wr_addr = AW'(cnt - CW'(2));
      wr_data = res;
    end else begin
      wr_addr = AW'(cnt);
      wr_data = value;
    end
  end

  // Both units sample the left operand straight from the RAM output in S_READ.
  rpn_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (rd_data),
    .b      (tos),
    .result (mul_res)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .left     (rd_data),
    .right    (tos),
    .done     (div_done),
    .quotient (div_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rpn_pkg::S_IDLE: begin
        if (accept) begin
          if (command inside {rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                              rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV} && !under) begin
            state_next = rpn_pkg::S_READ;
          end else begin
            state_next = rpn_pkg::S_DONE;
          end
        end
      end
      rpn_pkg::S_READ: begin
        case (cmd_q)
          rpn_pkg::CMD_MUL: state_next = rpn_pkg::S_MUL;
          rpn_pkg::CMD_DIV: state_next = (tos == '0) ? rpn_pkg::S_DONE : rpn_pkg::S_DIV;
          default:          state_next = rpn_pkg::S_WB;
        endcase
      end
      rpn_pkg::S_MUL: state_next = rpn_pkg::S_WB;
      rpn_pkg::S_DIV: begin
        if (div_done) begin
          state_next = rpn_pkg::S_WB;
        end
      end
      rpn_pkg::S_WB:  state_next = rpn_pkg::S_DONE;
      rpn_pkg::S_DONE: begin
        if (out_free) begin
          state_next = rpn_pkg::S_IDLE;
        end
      end
      default: state_next = rpn_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      rpn_pkg::S_IDLE: begin
        in_stall = 1'b0;
        mem_we   = do_push;
      end
      rpn_pkg::S_READ: begin
        mul_en    = 1'b1;
        div_start = (cmd_q == rpn_pkg::CMD_DIV) && (tos != '0);
      end
      rpn_pkg::S_WB:   mem_we   = 1'b1;
      rpn_pkg::S_DONE: out_load = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Depth counter and top-of-stack mirror
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (do_push) begin
      cnt <= cnt + CW'(1);
    end else if (state == rpn_pkg::S_WB) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      tos <= value;
    end else if (state == rpn_pkg::S_WB) begin
      tos <= res;
    end
  end

  // Item registers: command, status, result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      if (command == rpn_pkg::CMD_PUSH) begin
        res_status <= full ? rpn_pkg::ST_FULL : rpn_pkg::ST_OK;
      end else if (command inside {rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                                   rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV} && under) begin
        res_status <= rpn_pkg::ST_UNDER;
      end else begin
        res_status <= rpn_pkg::ST_OK;
      end
    end
    if (state == rpn_pkg::S_READ) begin
      if (cmd_q == rpn_pkg::CMD_ADD) begin
        res <= rd_data + tos;
      end else if (cmd_q == rpn_pkg::CMD_SUB) begin
        res <= rd_data - tos;
      end
      if ((cmd_q == rpn_pkg::CMD_DIV) && (tos == '0)) begin
        res_status <= rpn_pkg::ST_DIV0;
      end
    end
    if (state == rpn_pkg::S_MUL) begin
      res <= mul_res;
    end
    if ((state == rpn_pkg::S_DIV) && div_done) begin
      res <= div_res;
    end
  end

  // Output register: hold a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_value <= (cnt == '0) ? '0 : tos;
      status    <= res_status;
      depth     <= rpn_pkg::DEPTH_W'(cnt);
    end
  end

  // Checks
  property p_cnt_bound;
    @(posedge clk) disable iff (rst) cnt <= CW'(rpn_pkg::STACK_DEPTH);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("stack count beyond depth");

  property p_push_grows;
    @(posedge clk) disable iff (rst) do_push |=> (cnt == $past(cnt) + CW'(1));
  endproperty
  a_push_grows: assert property (p_push_grows) else $error("push did not grow stack");

  property p_wb_shrinks;
    @(posedge clk) disable iff (rst)
      (state == rpn_pkg::S_WB) |=> (cnt == $past(cnt) - CW'(1));
  endproperty
  a_wb_shrinks: assert property (p_wb_shrinks) else $error("operator did not pop");

  property p_div_done_in_div;
    @(posedge clk) disable iff (rst) div_done |-> (state == rpn_pkg::S_DIV);
  endproperty
  a_div_done_in_div: assert property (p_div_done_in_div) else $error("stray divider done");

  property p_wb_needs_two;
    @(posedge clk) disable iff (rst) (state == rpn_pkg::S_WB) |-> (cnt >= CW'(2));
  endproperty
  a_wb_needs_two: assert property (p_wb_needs_two) else $error("write-back on short stack");

endmodule
